FILE: design/vnfg_pkg.sv
// Shared constants and types for the value noise fBm generator.
package vnfg_pkg;

  localparam int unsigned MaxOctaves = 8;
  localparam int unsigned OctW       = $clog2(MaxOctaves + 1);
  localparam int unsigned OctIdxW    = (MaxOctaves > 1) ? $clog2(MaxOctaves) : 1;
  localparam int unsigned NumRegs    = 3;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned AmpW       = 17;
  localparam int unsigned TotalW     = 24 + AmpW + OctW;
  localparam int unsigned SumW       = AmpW + OctW;
  localparam int unsigned QuotW      = 25;
  localparam int unsigned DivSteps   = QuotW;
  localparam int unsigned OctLat     = 11;

  localparam logic [CfgIdxW-1:0] RegSeed    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOctaves = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPersist = 2'd2;

  localparam logic [63:0] MixC1    = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MixC2    = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] MixC3    = 64'h165667B19E3779F9;
  localparam logic [63:0] MixC4    = 64'h94D049BB133111EB;
  localparam logic [63:0] SeedStep = 64'd73856093;
  localparam logic [24:0] OneQ24   = 25'h1000000;
  localparam logic [16:0] OneQ16   = 17'h10000;

  // Per-point settings that travel with each request down the chain.
  typedef struct packed {
    logic [63:0]     seed;
    logic [OctW-1:0] octaves;
    logic [16:0]     persist;
  } cfg_t;

  typedef struct packed {
    logic [31:0]       cx;
    logic [31:0]       cy;
    cfg_t              cfg;
    logic [AmpW-1:0]   amp;
    logic [TotalW-1:0] total;
    logic [SumW-1:0]   amp_sum;
  } acc_t;

endpackage

FILE: design/vnfg_octave_cell.sv
// One octave cell: lattice hash, quintic fade, bilinear blend and weighted accumulation, pipelined.
module vnfg_octave_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [vnfg_pkg::OctIdxW-1:0] oct_i,
  input  logic                    valid_i,
  input  vnfg_pkg::acc_t          acc_i,
  output logic                    valid_o,
  output vnfg_pkg::acc_t          acc_o
);

  localparam int unsigned Lat = vnfg_pkg::OctLat;

  // Stage 0: shift coordinates, split index and fraction, seed offset.
  logic [63:0] sx, sy;
  logic [31:0] ix_d, iy_d;
  logic [23:0] tu_d, tv_d;
  logic [63:0] s_d;
  logic [63:0] oct_seed;
  assign oct_seed = 64'(oct_i) * vnfg_pkg::SeedStep;
  assign sx = {{32{acc_i.cx[31]}}, acc_i.cx} << oct_i;
  assign sy = {{32{acc_i.cy[31]}}, acc_i.cy} << oct_i;
  assign ix_d = sx[47:16];
  assign iy_d = sy[47:16];
  assign tu_d = {sx[15:0], 8'h00};
  assign tv_d = {sy[15:0], 8'h00};
  assign s_d  = acc_i.cfg.seed + oct_seed;

  logic [31:0] ix_q, iy_q, ix1_q, iy1_q;
  logic [23:0] tu_q, tv_q;
  logic [63:0] s_q;

  always_ff @(posedge clk_i) begin
    ix_q  <= ix_d;
    iy_q  <= iy_d;
    ix1_q <= ix_d + 32'd1;
    iy1_q <= iy_d + 32'd1;
    tu_q  <= tu_d;
    tv_q  <= tv_d;
    s_q   <= s_d;
  end

  // Stage 1: mixer products in 32-bit pieces; fade squares.
  // Operands 0 to 3 are the sign-extended indices ix, ix+1, iy, iy+1; operand 4 is the seed.
  logic [63:0] op_a [5];
  logic [63:0] op_b [5];
  logic [63:0] pl_q [5];
  logic [31:0] ph_q [5];
  logic [23:0] tu2_q, tv2_q, tu1_q, tv1_q;
  logic [47:0] tu_sq, tv_sq;
  assign op_a[0] = {{32{ix_q[31]}}, ix_q};
  assign op_a[1] = {{32{ix1_q[31]}}, ix1_q};
  assign op_a[2] = {{32{iy_q[31]}}, iy_q};
  assign op_a[3] = {{32{iy1_q[31]}}, iy1_q};
  assign op_a[4] = s_q;
  assign op_b[0] = vnfg_pkg::MixC1;
  assign op_b[1] = vnfg_pkg::MixC1;
  assign op_b[2] = vnfg_pkg::MixC2;
  assign op_b[3] = vnfg_pkg::MixC2;
  assign op_b[4] = vnfg_pkg::MixC3;
  assign tu_sq = 48'(tu_q) * 48'(tu_q);
  assign tv_sq = 48'(tv_q) * 48'(tv_q);

  // The upper word only needs the low halves of the two cross products.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 5; k++) begin
      pl_q[k] <= 64'(op_a[k][31:0]) * 64'(op_b[k][31:0]);
      ph_q[k] <= 32'(op_a[k][31:0] * op_b[k][63:32]) + 32'(op_a[k][63:32] * op_b[k][31:0]);
    end
    tu2_q <= tu_sq[47:24];
    tv2_q <= tv_sq[47:24];
    tu1_q <= tu_q;
    tv1_q <= tv_q;
  end

  // Stage 2: pieces summed into the products; t3 and the quadratic factor.
  logic [63:0] p_q [5];
  logic [23:0] tu3_q, tv3_q;
  logic [27:0] qu_q, qv_q;
  logic [47:0] tu_cu, tv_cu;
  assign tu_cu = 48'(tu2_q) * 48'(tu1_q);
  assign tv_cu = 48'(tv2_q) * 48'(tv1_q);

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 5; k++) begin
      p_q[k] <= pl_q[k] + {ph_q[k], 32'd0};
    end
    tu3_q  <= tu_cu[47:24];
    tv3_q  <= tv_cu[47:24];
    qu_q   <= 28'(6 * 28'(tu2_q)) + 28'(10 * 28'(vnfg_pkg::OneQ24)) - 28'(15 * 28'(tu1_q));
    qv_q   <= 28'(6 * 28'(tv2_q)) + 28'(10 * 28'(vnfg_pkg::OneQ24)) - 28'(15 * 28'(tv1_q));
  end

  // Stage 3: xor, first xorshift; fade product.
  logic [63:0] x0, x1, x2, x3;
  logic [63:0] y_q [4];
  logic [23:0] fu_q, fv_q;
  logic [51:0] fu_p, fv_p;
  assign x0 = p_q[0] ^ p_q[2] ^ p_q[4];
  assign x1 = p_q[1] ^ p_q[2] ^ p_q[4];
  assign x2 = p_q[0] ^ p_q[3] ^ p_q[4];
  assign x3 = p_q[1] ^ p_q[3] ^ p_q[4];
  assign fu_p = 52'(tu3_q) * 52'(qu_q);
  assign fv_p = 52'(tv3_q) * 52'(qv_q);

  always_ff @(posedge clk_i) begin
    y_q[0] <= x0 ^ (x0 >> 27);
    y_q[1] <= x1 ^ (x1 >> 27);
    y_q[2] <= x2 ^ (x2 >> 27);
    y_q[3] <= x3 ^ (x3 >> 27);
    fu_q <= fu_p[47:24];
    fv_q <= fv_p[47:24];
  end

  // Stage 4: pieces of the second mixer multiply.
  logic [63:0] ml_q [4];
  logic [31:0] mh_q [4];
  logic [23:0] fua_q, fva_q;
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      ml_q[k] <= 64'(y_q[k][31:0]) * 64'(vnfg_pkg::MixC4[31:0]);
      mh_q[k] <= 32'(y_q[k][31:0] * vnfg_pkg::MixC4[63:32])
               + 32'(y_q[k][63:32] * vnfg_pkg::MixC4[31:0]);
    end
    fua_q <= fu_q;
    fva_q <= fv_q;
  end

  // Stage 5: second mixer product.
  logic [63:0] m_q [4];
  logic [23:0] fub_q, fvb_q;
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      m_q[k] <= ml_q[k] + {mh_q[k], 32'd0};
    end
    fub_q <= fua_q;
    fvb_q <= fva_q;
  end

  // Stage 6: final xorshift keeps 24 bits of each corner.
  logic [23:0] h_q [4];
  logic [23:0] fu4_q, fv4_q;
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      h_q[k] <= m_q[k][23:0] ^ m_q[k][54:31];
    end
    fu4_q <= fub_q;
    fv4_q <= fvb_q;
  end

  // Stage 7: horizontal blends.
  logic [24:0] wu_inv;
  logic [48:0] la, lb;
  logic [23:0] ba_q, bb_q, fv5_q;
  assign wu_inv = vnfg_pkg::OneQ24 - 25'(fu4_q);
  assign la = 49'(h_q[0]) * 49'(wu_inv) + 49'(h_q[1]) * 49'(fu4_q);
  assign lb = 49'(h_q[2]) * 49'(wu_inv) + 49'(h_q[3]) * 49'(fu4_q);
  always_ff @(posedge clk_i) begin
    ba_q  <= la[47:24];
    bb_q  <= lb[47:24];
    fv5_q <= fv4_q;
  end

  // Stage 8: vertical blend.
  logic [24:0] wv_inv;
  logic [48:0] lc;
  logic [23:0] val_q;
  assign wv_inv = vnfg_pkg::OneQ24 - 25'(fv5_q);
  assign lc = 49'(ba_q) * 49'(wv_inv) + 49'(bb_q) * 49'(fv5_q);
  always_ff @(posedge clk_i) begin
    val_q <= lc[47:24];
  end

  // Stage 9: weight the octave value.
  logic [40:0] wprod_q;
  logic        act_q;

  // Accumulator travels alongside; an inactive octave passes it unchanged.
  vnfg_pkg::acc_t acc_pipe_q [Lat-1];
  logic [Lat-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    acc_pipe_q[0] <= acc_i;
    for (int k = 1; k < Lat - 1; k++) begin
      acc_pipe_q[k] <= acc_pipe_q[k-1];
    end
  end

  vnfg_pkg::acc_t a7;
  assign a7 = acc_pipe_q[Lat-3];
  always_ff @(posedge clk_i) begin
    wprod_q <= 41'(val_q) * 41'(a7.amp);
    act_q   <= (5'(oct_i) < 5'(a7.cfg.octaves));
  end

  // Stage 10: accumulate and form the next amplitude.
  vnfg_pkg::acc_t a8, acc_d, acc_q;
  logic [33:0] amp_next;
  assign a8 = acc_pipe_q[Lat-2];
  assign amp_next = 34'(a8.amp) * 34'(a8.cfg.persist);
  always_comb begin
    acc_d = a8;
    if (act_q) begin
      acc_d.total   = a8.total + vnfg_pkg::TotalW'(wprod_q);
      acc_d.amp_sum = a8.amp_sum + vnfg_pkg::SumW'(a8.amp);
      acc_d.amp     = amp_next[32:16];
    end
  end
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign valid_o = vld_q[Lat-1];
  assign acc_o   = acc_q;

endmodule

FILE: design/vnfg_div_cell.sv
// One restoring-division cell: produces one quotient bit per stage.
module vnfg_div_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [vnfg_pkg::TotalW-1:0]   rem_i,
  input  logic [vnfg_pkg::TotalW-1:0]   num_i,
  input  logic [vnfg_pkg::SumW-1:0]     den_i,
  input  logic [vnfg_pkg::QuotW-1:0]    quo_i,
  output logic                          valid_o,
  output logic [vnfg_pkg::TotalW-1:0]   rem_o,
  output logic [vnfg_pkg::TotalW-1:0]   num_o,
  output logic [vnfg_pkg::SumW-1:0]     den_o,
  output logic [vnfg_pkg::QuotW-1:0]    quo_o
);

  logic [vnfg_pkg::TotalW:0] trial;
  logic                      fits;
  assign trial = {rem_i, num_i[vnfg_pkg::TotalW-1]};
  assign fits  = trial >= (vnfg_pkg::TotalW + 1)'(den_i);

  logic valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_o <= fits ? vnfg_pkg::TotalW'(trial - (vnfg_pkg::TotalW + 1)'(den_i))
                  : vnfg_pkg::TotalW'(trial);
    num_o <= num_i << 1;
    den_o <= den_i;
    quo_o <= {quo_i[vnfg_pkg::QuotW-2:0], fits};
  end

  assign valid_o = valid_q;

endmodule

FILE: design/value_noise_fbm_generator_unit.sv
// Top level: a chain of octave cells followed by a chain of divider cells.
// Each request passes 1 input stage, the MaxOctaves octave cells and 25 divider
// stages; a new request is accepted every cycle, busy stays low.
// Throughput: one point per clock; each result strobes valid_o for one cycle.
// Reset clears the valid chain and loads the register defaults: seed 0,
// four octaves, persistence 36045. Results cannot be stalled by the receiver.
module value_noise_fbm_generator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [31:0]             coord_x_i,
  input  logic signed [31:0]             coord_y_i,
  input  logic                           cfg_we_i,
  input  logic [vnfg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [vnfg_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                           valid_o,
  output logic [23:0]                    noise_value_o
);

  localparam int unsigned N = vnfg_pkg::MaxOctaves;
  localparam int unsigned D = vnfg_pkg::DivSteps;

  logic [63:0] seed_q;
  logic [3:0]  oct_q;
  logic [16:0] pers_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      oct_q  <= 4'd4;
      pers_q <= 17'd36045;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vnfg_pkg::RegSeed:    seed_q <= cfg_data_i;
        vnfg_pkg::RegOctaves: oct_q  <= cfg_data_i[3:0];
        vnfg_pkg::RegPersist: pers_q <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Clamp settings once per request.
  vnfg_pkg::acc_t in_d, in_q;
  logic           in_vld_q;
  always_comb begin
    in_d = '0;
    in_d.cx = coord_x_i;
    in_d.cy = coord_y_i;
    in_d.cfg.seed = seed_q;
    if (oct_q == 4'd0) begin
      in_d.cfg.octaves = vnfg_pkg::OctW'(1);
    end else if (32'(oct_q) > N) begin
      in_d.cfg.octaves = vnfg_pkg::OctW'(N);
    end else begin
      in_d.cfg.octaves = vnfg_pkg::OctW'(oct_q);
    end
    in_d.cfg.persist = (pers_q > vnfg_pkg::OneQ16) ? vnfg_pkg::OneQ16 : pers_q;
    in_d.amp = vnfg_pkg::OneQ16;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end
  always_ff @(posedge clk_i) begin
    in_q <= in_d;
  end

  logic           c_vld [N+1];
  vnfg_pkg::acc_t c_acc [N+1];
  assign c_vld[0] = in_vld_q;
  assign c_acc[0] = in_q;

  for (genvar g = 0; g < N; g++) begin : g_oct
    vnfg_octave_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .oct_i   (vnfg_pkg::OctIdxW'(g)),
      .valid_i (c_vld[g]),
      .acc_i   (c_acc[g]),
      .valid_o (c_vld[g+1]),
      .acc_o   (c_acc[g+1])
    );
  end

  logic                        d_vld [D+1];
  logic [vnfg_pkg::TotalW-1:0] d_rem [D+1];
  logic [vnfg_pkg::TotalW-1:0] d_num [D+1];
  logic [vnfg_pkg::SumW-1:0]   d_den [D+1];
  logic [vnfg_pkg::QuotW-1:0]  d_quo [D+1];

  // Numerator is pre-shifted so that its low QuotW bits are brought in, most significant first.
  assign d_vld[0] = c_vld[N];
  assign d_rem[0] = vnfg_pkg::TotalW'(c_acc[N].total >> vnfg_pkg::QuotW);
  assign d_num[0] = c_acc[N].total << (vnfg_pkg::TotalW - vnfg_pkg::QuotW);
  assign d_den[0] = c_acc[N].amp_sum;
  assign d_quo[0] = '0;

  for (genvar g = 0; g < D; g++) begin : g_div
    vnfg_div_cell u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (d_vld[g]),
      .rem_i   (d_rem[g]),
      .num_i   (d_num[g]),
      .den_i   (d_den[g]),
      .quo_i   (d_quo[g]),
      .valid_o (d_vld[g+1]),
      .rem_o   (d_rem[g+1]),
      .num_o   (d_num[g+1]),
      .den_o   (d_den[g+1]),
      .quo_o   (d_quo[g+1])
    );
  end

  assign valid_o       = d_vld[D];
  assign noise_value_o = d_quo[D][23:0];

`ifndef SYNTHESIS
  a_busy_low: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy asserted");
  a_in_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> in_vld_q) else $error("request not captured");
  a_den_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_vld[0] |-> (d_den[0] != '0)) else $error("zero amplitude sum");
  a_oct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q |-> (in_q.cfg.octaves != '0)) else $error("octave count zero");
`endif

endmodule
